FILE: sv/scrolling_text_line_buffer_unit_defines.svh
// Assertion macros shared by the scrolling text line buffer RTL.
`ifndef SCROLLING_TEXT_LINE_BUFFER_UNIT_DEFINES_SVH
`define SCROLLING_TEXT_LINE_BUFFER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define STLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define STLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/stlb_pkg.sv
// Types and constants of the scrolling text line buffer.
package stlb_pkg;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [3:0] MAX_LINES_RST = 4'd4;
    localparam logic [3:0] LINES_SAT     = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDATA,
        ST_BS1,
        ST_BS2,
        ST_STORE,
        ST_COUNT,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DROP_END,
        ST_DONE
    } t_state;

    typedef enum logic {
        RET_STORE,
        RET_DONE
    } t_ret;
endpackage

FILE: sv/stlb_ram.sv
// Character store: one write port, one read port with registered read data.
module stlb_ram
    import stlb_pkg::*;
#(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [CHAR_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_data
);
    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: sv/scrolling_text_line_buffer_unit.sv
// Scrolling text line buffer: console text store with line scrolling.
//
// Input words carry one access: tuser is the command (0 add a character,
// 1 read a stored character), tdata holds the character code and the read
// index. Every accepted word gives exactly one output word with the read
// character (0 for writes and for reads past the live text), the fill level
// and the count of completed lines.
// A read passes through ST_RDATA when its index is in range; a plain
// character is stored, and a carriage return stores CR, then LF, and counts
// the line. Backspace also drops a CR before a removed LF. A scroll searches
// the character memory for the first line feed one character at a time and
// then moves the remaining text down one character at a time, because
// the single memory port pair does one read or one read-write per step. One
// carriage return can trigger up to three scrolls. One item is processed at
// a time.
// The output register holds a finished word while the receiver stalls; the
// next input word can already be accepted and processed, and it waits at
// its end until the output register is free.
// Reset empties the text, clears the line count and sets max_lines to 4.
// The memory contents need no clearing: only live text is ever read.
`include "scrolling_text_line_buffer_unit_defines.svh"
module scrolling_text_line_buffer_unit
    import stlb_pkg::*;
#(
    parameter int CAPACITY = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // char_code [7:0], read_index [15:8]
    input  logic        i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // read_data [7:0], fill_level [15:8], line_count [19:16]
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);
    localparam int AW  = $clog2(CAPACITY);
    localparam int WPW = $clog2(CAPACITY + 1);
    localparam int CW  = (WPW > 8) ? WPW : 8;

    t_state            r_state, n_state;
    t_ret              r_ret, n_ret;
    logic [WPW-1:0]    r_wp, n_wp;
    logic [3:0]        r_lines, n_lines;
    logic [3:0]        r_max_lines;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_crlf, n_crlf;
    logic [WPW-1:0]    r_idx, n_idx;
    logic [WPW-1:0]    r_j, n_j;
    logic [WPW-1:0]    r_cut, n_cut;
    logic [CHAR_W-1:0] r_rdata, n_rdata;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_data;
    logic [7:0]        r_out_fill;
    logic [3:0]        r_out_lines;

    logic [CHAR_W-1:0] w_char;
    logic [CW-1:0]     w_idx_ext;
    logic [CW-1:0]     w_wp_ext;
    logic              w_in_range;
    logic              w_full;
    logic [WPW-1:0]    w_wp_m1;
    logic [WPW-1:0]    w_wp_m2;
    logic [WPW-1:0]    w_dst;
    logic [3:0]        w_lines_inc;
    logic              w_load;

    logic              w_we;
    logic [AW-1:0]     w_wr_addr;
    logic [CHAR_W-1:0] w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [CHAR_W-1:0] w_rd_data;

    stlb_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_char      = i_s_tdata[7:0];
    assign w_idx_ext   = CW'(i_s_tdata[15:8]);
    assign w_wp_ext    = CW'(r_wp);
    assign w_in_range  = w_idx_ext < w_wp_ext;
    assign w_full      = r_wp == WPW'(CAPACITY);
    assign w_wp_m1     = r_wp - 1'b1;
    assign w_wp_m2     = r_wp - 2'd2;
    assign w_dst       = r_j - r_cut;
    assign w_lines_inc = (r_lines == LINES_SAT) ? r_lines : r_lines + 1'b1;

    assign o_s_tready = r_state == ST_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_lines, r_out_fill, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_lines     <= '0;
            r_max_lines <= MAX_LINES_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_lines <= n_lines;
            if (i_cfg_we) begin
                r_max_lines <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_char  <= n_char;
        r_crlf  <= n_crlf;
        r_idx   <= n_idx;
        r_j     <= n_j;
        r_cut   <= n_cut;
        r_rdata <= n_rdata;
        if (w_load) begin
            r_out_data  <= r_rdata;
            r_out_fill  <= w_wp_ext[7:0];
            r_out_lines <= r_lines;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_wp      = r_wp;
        n_lines   = r_lines;
        n_char    = r_char;
        n_crlf    = r_crlf;
        n_idx     = r_idx;
        n_j       = r_j;
        n_cut     = r_cut;
        n_rdata   = r_rdata;
        w_rd_addr = '0;
        w_we      = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_char;
        w_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_rdata = '0;
                    if (i_s_tuser == CMD_READ) begin
                        w_rd_addr = w_idx_ext[AW-1:0];
                        n_state   = w_in_range ? ST_RDATA : ST_DONE;
                    end else if (w_char == CH_BS) begin
                        w_rd_addr = w_wp_m1[AW-1:0];
                        n_state   = (r_wp == '0) ? ST_DONE : ST_BS1;
                    end else if (w_char == CH_FF) begin
                        n_wp    = '0;
                        n_lines = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_char  = w_char;
                        n_crlf  = 1'b0;
                        n_state = ST_STORE;
                    end
                end
            end
            ST_RDATA: begin
                n_rdata = w_rd_data;
                n_state = ST_DONE;
            end
            ST_BS1: begin
                n_state = ST_DONE;
                n_wp    = w_wp_m1;
                if (w_rd_data == CH_LF) begin
                    if (r_lines != '0) begin
                        n_lines = r_lines - 1'b1;
                    end
                    if (r_wp > WPW'(1)) begin
                        w_rd_addr = w_wp_m2[AW-1:0];
                        n_wp      = r_wp;
                        n_state   = ST_BS2;
                    end
                end
            end
            ST_BS2: begin
                n_wp    = (w_rd_data == CH_CR) ? w_wp_m2 : w_wp_m1;
                n_state = ST_DONE;
            end
            ST_STORE: begin
                if (w_full) begin
                    n_idx   = '0;
                    n_ret   = RET_STORE;
                    n_state = ST_SRCH_RD;
                end else begin
                    w_we      = 1'b1;
                    w_wr_addr = r_wp[AW-1:0];
                    n_wp      = r_wp + 1'b1;
                    if (r_char == CH_CR) begin
                        n_char = CH_LF;
                        n_crlf = 1'b1;
                    end else if (r_crlf) begin
                        n_state = ST_COUNT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_COUNT: begin
                n_lines = w_lines_inc;
                if (w_lines_inc >= r_max_lines) begin
                    n_idx   = '0;
                    n_ret   = RET_DONE;
                    n_state = ST_SRCH_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SRCH_RD: begin
                if (r_idx == r_wp) begin
                    n_state = ST_DROP_END;
                end else begin
                    w_rd_addr = r_idx[AW-1:0];
                    n_state   = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK: begin
                if (w_rd_data == CH_LF) begin
                    n_cut = r_idx + 1'b1;
                    n_j   = r_idx + 1'b1;
                    if (r_lines != '0) begin
                        n_lines = r_lines - 1'b1;
                    end
                    n_state = ST_SHIFT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (r_j == r_wp) begin
                    n_wp    = r_wp - r_cut;
                    n_state = ST_DROP_END;
                end else begin
                    w_rd_addr = r_j[AW-1:0];
                    n_state   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                w_we      = 1'b1;
                w_wr_addr = w_dst[AW-1:0];
                w_wr_data = w_rd_data;
                n_j       = r_j + 1'b1;
                n_state   = ST_SHIFT_RD;
            end
            ST_DROP_END: begin
                if (w_full) begin
                    n_wp    = '0;
                    n_lines = '0;
                end
                n_state = (r_ret == RET_STORE) ? ST_STORE : ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `STLB_ASSERT_IMP(a_wp_bound, i_clk, i_rst_n, 1'b1, r_wp <= WPW'(CAPACITY), "fill level beyond capacity")
    `STLB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != ST_IDLE, "accepted word left no work")
    `STLB_ASSERT_NXT(a_room_after_drop, i_clk, i_rst_n, (r_state == ST_DROP_END) && (r_ret == RET_STORE), r_wp < WPW'(CAPACITY), "store still full after line drop")
    `STLB_ASSERT_IMP(a_shift_order, i_clk, i_rst_n, r_state == ST_SHIFT_WR, (r_cut != '0) && (r_j < r_wp), "shift outside live text")
endmodule
